// File: sv/stsq_pkg.sv
// ----------------------------------------------------------------------------
// stsq_pkg
// Shared constants, codes and controller/datapath interface types for the
// square tone step sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package stsq_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int TAB_AW      = $clog2(TABLE_DEPTH);
    localparam int PHASE_BITS  = 24;

    // Divider sizing: the numerator is a 21-bit clock constant shifted by the
    // phase width, the divisor at most a 16-bit period times a 17-bit rate.
    localparam int CLK_W     = 21;
    localparam int DVD_W     = CLK_W + PHASE_BITS;
    localparam int DVS_W     = 33;
    localparam int REM_W     = DVS_W + 2;
    localparam int DIV_CNT_W = $clog2(DVD_W);

    localparam logic [CLK_W-1:0] TIMER_CLOCK = 21'd1193182;
    localparam logic [CLK_W-1:0] FREQ_LO     = 21'd80;
    localparam logic [CLK_W-1:0] FREQ_HI     = 21'd4200;
    localparam logic [15:0]      MUTE_LIMIT  = 16'h0020;
    localparam logic signed [13:0] AMP       = 14'sd7200;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_REQ  = 2'd1;
    localparam logic [1:0] OP_PUMP = 2'd2;
    localparam logic [1:0] OP_TICK = 2'd3;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_TABLE = 2'd1;
    localparam logic [1:0] MODE_SWEEP = 2'd2;

    localparam logic [2:0] CFG_STEP_COUNT  = 3'd0;
    localparam logic [2:0] CFG_STOP_PERIOD = 3'd1;
    localparam logic [2:0] CFG_SPT         = 3'd2;
    localparam logic [2:0] CFG_SAMPLE_RATE = 3'd3;
    localparam logic [2:0] CFG_SWEEP_THR   = 3'd4;
    localparam logic [2:0] CFG_SWEEP_BASE  = 3'd5;

    typedef struct packed {
        logic capture;
        logic exec;
        logic adv;
        logic load;
        logic entry;
        logic tone;
        logic div_step;
        logic fail;
        logic post;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       latch_active;
        logic       mode_idle;
        logic       mode_table;
        logic       step_end;
        logic       adv_ok;
        logic       load_ok;
        logic       entry_ok;
        logic       muted;
        logic       div_done;
        logic       slot_free;
    } t_stat;

endpackage

`default_nettype wire

// File: sv/stsq_ram.sv
// ----------------------------------------------------------------------------
// stsq_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module stsq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: sv/stsq_ctrl.sv
// ----------------------------------------------------------------------------
// stsq_ctrl
// Sequencer that steps one word through execute, step advance, table fetch,
// entry check, tone setup, divide, end of sound and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module stsq_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    input  stsq_pkg::t_stat i_stat,
    output stsq_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_ADV   = 4'd2;
    localparam logic [3:0] S_LOAD  = 4'd3;
    localparam logic [3:0] S_ENTRY = 4'd4;
    localparam logic [3:0] S_TONE  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_FAIL  = 4'd7;
    localparam logic [3:0] S_POST  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        o_in_ready     = (r_state == S_IDLE);
        o_cmd          = '0;
        o_cmd.capture  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.exec     = (r_state == S_EXEC);
        o_cmd.adv      = (r_state == S_ADV);
        o_cmd.load     = (r_state == S_LOAD);
        o_cmd.entry    = (r_state == S_ENTRY);
        o_cmd.tone     = (r_state == S_TONE);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.fail     = (r_state == S_FAIL);
        o_cmd.post     = (r_state == S_POST);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_stat.op == stsq_pkg::OP_PUMP && i_stat.latch_active) begin
                    n_state = S_LOAD;
                end else if (i_stat.op == stsq_pkg::OP_TICK && !i_stat.mode_idle
                             && i_stat.step_end) begin
                    n_state = S_ADV;
                end else begin
                    n_state = S_POST;
                end
            end
            S_ADV: begin
                n_state = i_stat.adv_ok ? S_LOAD : S_FAIL;
            end
            S_LOAD: begin
                if (!i_stat.load_ok)        n_state = S_FAIL;
                else if (i_stat.mode_table) n_state = S_ENTRY;
                else                        n_state = S_TONE;
            end
            S_ENTRY: begin
                n_state = i_stat.entry_ok ? S_TONE : S_FAIL;
            end
            S_TONE: begin
                n_state = i_stat.muted ? S_POST : S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) n_state = S_POST;
            end
            S_FAIL: begin
                n_state = S_POST;
            end
            S_POST: begin
                if (i_stat.slot_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_div_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !i_stat.div_done) |=> (r_state == S_DIV))
        else $error("divider left before its last step");

    a_post_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POST && i_stat.slot_free) |=> (r_state == S_IDLE))
        else $error("result hand-off did not return to idle");

    a_fail_posts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FAIL) |=> (r_state == S_POST))
        else $error("end of sound not followed by hand-off");

endmodule

`default_nettype wire

// File: sv/stsq_dp.sv
// ----------------------------------------------------------------------------
// stsq_dp
// Datapath: configuration, step table, priority latch, playback state,
// phase accumulator, serial increment divider and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stsq_dp (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_cfg_we,
    input  wire [2:0]       i_cfg_index,
    input  wire [16:0]      i_cfg_data,
    input  wire [1:0]       i_op,
    input  wire [9:0]       i_entry_index,
    input  wire [15:0]      i_entry_period,
    input  wire [7:0]       i_entry_gate,
    input  wire [7:0]       i_entry_ticks,
    input  wire [15:0]      i_cursor,
    input  wire [7:0]       i_priority_req,
    input  stsq_pkg::t_cmd  i_cmd,
    output stsq_pkg::t_stat o_stat,
    output logic            o_out_valid,
    input  wire             i_out_ready,
    output logic [15:0]     o_out_data,
    output logic            o_out_last
);

    localparam int PB = stsq_pkg::PHASE_BITS;

    // Configuration.
    logic [10:0] r_step_count, r_spt;
    logic [15:0] r_stop, r_thr, r_base;
    logic [16:0] r_rate;

    // Captured word.
    logic [1:0]  r_op;
    logic [9:0]  r_idx;
    logic [15:0] r_eper, r_cur;
    logic [7:0]  r_egate, r_eticks, r_prio;

    // Play state.
    logic        r_latch_act;
    logic [7:0]  r_latch_pri;
    logic [15:0] r_latch_cur;
    logic [1:0]  r_mode;
    logic [15:0] r_ptr;
    logic [PB-1:0] r_phase, r_inc;
    logic [18:0] r_tone_left, r_sil_left;
    logic        r_muted;
    logic [15:0] r_period;
    logic        r_from_tick;

    // Result being built.
    logic               r_acc, r_playing, r_last;
    logic signed [13:0] r_sample;

    // Divider.
    logic [stsq_pkg::REM_W-1:0]     r_rem;
    logic [stsq_pkg::DVD_W-1:0]     r_dvd;
    logic [stsq_pkg::DVS_W-1:0]     r_dvs;
    logic [PB-1:0]                  r_quo;
    logic [stsq_pkg::DIV_CNT_W-1:0] r_cnt;

    logic [31:0] ram_rdata;
    logic        ram_we;

    stsq_ram #(
        .WIDTH(32),
        .DEPTH(stsq_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_idx[stsq_pkg::TAB_AW-1:0]),
        .i_wdata({r_eticks, r_egate, r_eper}),
        .i_raddr(r_ptr[stsq_pkg::TAB_AW-1:0]),
        .o_rdata(ram_rdata)
    );

    assign ram_we = i_cmd.exec && (r_op == stsq_pkg::OP_LOAD)
                    && ({7'd0, r_idx} < 17'(stsq_pkg::TABLE_DEPTH));

    // Tick bookkeeping.
    logic [18:0] tk_tone, tk_sil;
    logic [PB-1:0] tk_phase;
    always_comb begin
        tk_tone = r_tone_left;
        tk_sil  = r_sil_left;
        if (r_tone_left != '0)     tk_tone = r_tone_left - 19'd1;
        else if (r_sil_left != '0) tk_sil  = r_sil_left - 19'd1;
        tk_phase = r_phase + r_inc;
    end

    logic req_win;
    assign req_win = !r_latch_act || ((r_latch_pri - 8'd1) < r_prio);

    // Entry decode.
    logic [7:0]  en_gate;
    logic [8:0]  en_ticks, en_aud;
    logic [19:0] en_tone, en_sil;
    always_comb begin
        en_gate  = ram_rdata[23:16];
        en_ticks = (ram_rdata[31:24] == 8'd0) ? 9'd256 : {1'b0, ram_rdata[31:24]};
        en_aud   = (en_gate != 8'd0 && {1'b0, en_gate} < en_ticks)
                   ? {1'b0, en_gate} : en_ticks;
        en_tone  = en_aud * r_spt;
        en_sil   = (en_ticks - en_aud) * r_spt;
    end

    logic [15:0] sw_period;
    assign sw_period = ((r_ptr - r_base) == 16'd0) ? 16'd1 : (r_ptr - r_base);

    // Increment setup: clamp to the low or high frequency and divide it by the rate,
    // else divide the clock by period times rate.
    logic [16:0] rate1;
    logic        clamp_lo, clamp_hi;
    logic [stsq_pkg::CLK_W-1:0] num;
    always_comb begin
        rate1    = (r_rate == 17'd0) ? 17'd1 : r_rate;
        clamp_lo = ({7'd0, r_period} * 23'd80) > 23'(stsq_pkg::TIMER_CLOCK);
        clamp_hi = ({13'd0, r_period} * 29'd4200) < 29'(stsq_pkg::TIMER_CLOCK);
        num      = clamp_lo ? stsq_pkg::FREQ_LO
                 : (clamp_hi ? stsq_pkg::FREQ_HI : stsq_pkg::TIMER_CLOCK);
    end

    // One restoring divide step per cycle.
    logic [stsq_pkg::REM_W-1:0] dv_sh, dv_rem;
    logic                       dv_ge;
    always_comb begin
        dv_sh  = {r_rem[stsq_pkg::REM_W-2:0], r_dvd[stsq_pkg::DVD_W-1]};
        dv_ge  = dv_sh >= {2'b00, r_dvs};
        dv_rem = dv_ge ? (dv_sh - {2'b00, r_dvs}) : dv_sh;
    end

    logic div_done;
    assign div_done = (r_cnt == stsq_pkg::DIV_CNT_W'(stsq_pkg::DVD_W - 1));

    always_comb begin
        o_stat.op           = r_op;
        o_stat.latch_active = r_latch_act;
        o_stat.mode_idle    = (r_mode == stsq_pkg::MODE_IDLE);
        o_stat.mode_table   = (r_mode == stsq_pkg::MODE_TABLE);
        o_stat.step_end     = (tk_tone == '0) && (tk_sil == '0);
        if (r_mode == stsq_pkg::MODE_TABLE) begin
            o_stat.adv_ok  = (r_ptr != 16'hFFFF);
            o_stat.load_ok = (r_ptr < {5'd0, r_step_count})
                             && ({1'b0, r_ptr} < 17'(stsq_pkg::TABLE_DEPTH));
        end else begin
            o_stat.adv_ok  = (r_ptr >= 16'd4) && ((r_ptr - 16'd4) > r_thr);
            o_stat.load_ok = (r_spt[10:1] != 10'd0);
        end
        o_stat.entry_ok  = (ram_rdata[15:0] != r_stop);
        o_stat.muted     = (r_period < stsq_pkg::MUTE_LIMIT);
        o_stat.div_done  = div_done;
        o_stat.slot_free = !o_out_valid || i_out_ready;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_count <= 11'd0;
            r_stop       <= 16'hFFFF;
            r_spt        <= 11'd64;
            r_rate       <= 17'd44100;
            r_thr        <= 16'hFFFF;
            r_base       <= 16'd0;
            r_latch_act  <= 1'b0;
            r_latch_pri  <= 8'd0;
            r_latch_cur  <= 16'd0;
            r_mode       <= stsq_pkg::MODE_IDLE;
            r_ptr        <= 16'd0;
            r_phase      <= '0;
            r_inc        <= '0;
            r_tone_left  <= '0;
            r_sil_left   <= '0;
            r_muted      <= 1'b0;
            o_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    stsq_pkg::CFG_STEP_COUNT:  r_step_count <= i_cfg_data[10:0];
                    stsq_pkg::CFG_STOP_PERIOD: r_stop       <= i_cfg_data[15:0];
                    stsq_pkg::CFG_SPT:         r_spt        <= i_cfg_data[10:0];
                    stsq_pkg::CFG_SAMPLE_RATE: r_rate       <= i_cfg_data;
                    stsq_pkg::CFG_SWEEP_THR:   r_thr        <= i_cfg_data[15:0];
                    stsq_pkg::CFG_SWEEP_BASE:  r_base       <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_cmd.exec) begin
                case (r_op)
                    stsq_pkg::OP_REQ: begin
                        if (req_win) begin
                            r_latch_act <= 1'b1;
                            r_latch_pri <= r_prio;
                            r_latch_cur <= r_cur;
                        end
                    end
                    stsq_pkg::OP_PUMP: begin
                        if (r_latch_act) begin
                            r_latch_act <= 1'b0;
                            r_latch_pri <= 8'd0;
                            r_latch_cur <= 16'd0;
                            r_ptr       <= r_latch_cur;
                            r_phase     <= '0;
                            r_mode      <= (r_latch_cur > r_thr) ? stsq_pkg::MODE_SWEEP
                                                                 : stsq_pkg::MODE_TABLE;
                        end
                    end
                    stsq_pkg::OP_TICK: begin
                        if (r_mode != stsq_pkg::MODE_IDLE) begin
                            r_tone_left <= tk_tone;
                            r_sil_left  <= tk_sil;
                            if (r_tone_left != '0 && !r_muted) r_phase <= tk_phase;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.adv) begin
                r_ptr <= (r_mode == stsq_pkg::MODE_TABLE) ? r_ptr + 16'd1 : r_ptr - 16'd4;
            end
            if (i_cmd.load && r_mode == stsq_pkg::MODE_SWEEP) begin
                r_tone_left <= {9'd0, r_spt[10:1]};
                r_sil_left  <= '0;
            end
            if (i_cmd.entry) begin
                r_tone_left <= (en_tone == 20'd0) ? 19'd1 : en_tone[18:0];
                r_sil_left  <= en_sil[18:0];
            end
            if (i_cmd.tone) begin
                r_muted <= o_stat.muted;
                if (o_stat.muted) r_inc <= '0;
            end
            if (i_cmd.div_step && div_done) begin
                r_inc <= {r_quo[PB-2:0], dv_ge};
            end
            if (i_cmd.fail) begin
                r_mode      <= stsq_pkg::MODE_IDLE;
                r_tone_left <= '0;
                r_sil_left  <= '0;
            end
            if (i_cmd.post && o_stat.slot_free) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= i_op;
            r_idx     <= i_entry_index;
            r_eper    <= i_entry_period;
            r_egate   <= i_entry_gate;
            r_eticks  <= i_entry_ticks;
            r_cur     <= i_cursor;
            r_prio    <= i_priority_req;
            r_acc     <= 1'b0;
            r_playing <= 1'b0;
            r_last    <= 1'b0;
            r_sample  <= '0;
        end
        if (i_cmd.exec) begin
            r_from_tick <= (r_op == stsq_pkg::OP_TICK);
            if (r_op == stsq_pkg::OP_REQ && req_win) r_acc <= 1'b1;
            if (r_op == stsq_pkg::OP_TICK && r_mode != stsq_pkg::MODE_IDLE) begin
                r_playing <= 1'b1;
                if (r_tone_left != '0 && !r_muted) begin
                    r_sample <= tk_phase[PB-1] ? -stsq_pkg::AMP : stsq_pkg::AMP;
                end
            end
        end
        if (i_cmd.load && r_mode == stsq_pkg::MODE_SWEEP) r_period <= sw_period;
        if (i_cmd.entry) r_period <= ram_rdata[15:0];
        if (i_cmd.tone) begin
            r_rem <= '0;
            r_dvd <= {num, {PB{1'b0}}};
            r_dvs <= (clamp_lo || clamp_hi) ? {16'd0, rate1} : r_period * rate1;
            r_quo <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= dv_rem;
            r_dvd <= {r_dvd[stsq_pkg::DVD_W-2:0], 1'b0};
            r_quo <= {r_quo[PB-2:0], dv_ge};
            r_cnt <= r_cnt + stsq_pkg::DIV_CNT_W'(1);
        end
        if (i_cmd.fail) r_last <= r_from_tick;
        if (i_cmd.post && o_stat.slot_free) begin
            o_out_data <= {r_playing, r_sample, r_acc};
            o_out_last <= r_last;
        end
    end

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == stsq_pkg::MODE_IDLE) |-> (r_tone_left == '0 && r_sil_left == '0))
        else $error("idle player holds step counts");

    a_mute_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_muted |-> (r_inc == '0))
        else $error("muted tone has a nonzero increment");

    a_tick_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.fail && r_from_tick) |=> r_last)
        else $error("sound end on a tick not flagged as last");

endmodule

`default_nettype wire

// File: sv/square_tone_step_sequencer_core.sv
// A load, a request, a pump with an empty latch or a tick within a step goes through
// execute and result hand-off only. A step start adds the step advance on a tick, the
// step check, a table read for a table step, the tone setup and a serial restoring
// divide, which a muted period skips. One word is in work at a time and the next is
// accepted in the cycle after its result is posted; a full output register holds the
// result back. Sync active-low reset.
// ----------------------------------------------------------------------------
// square_tone_step_sequencer_core
// Square-wave sound effect player with a step table, priority latch and sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module square_tone_step_sequencer_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire [2:0]   i_cfg_index,
    input  wire [16:0]  i_cfg_data,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // entry_index[9:0], entry_period[25:10], entry_gate[33:26],
    // entry_ticks[41:34], cursor[57:42], priority_req[65:58], zero fill
    input  wire [71:0]  i_s_axis_tdata,
    // op[1:0]
    input  wire [1:0]   i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // accepted[0], sample[14:1], playing[15]
    output logic [15:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast
);

    stsq_pkg::t_cmd  cmd;
    stsq_pkg::t_stat stat;

    stsq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_s_axis_tvalid),
        .o_in_ready(o_s_axis_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    stsq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_op          (i_s_axis_tuser),
        .i_entry_index (i_s_axis_tdata[9:0]),
        .i_entry_period(i_s_axis_tdata[25:10]),
        .i_entry_gate  (i_s_axis_tdata[33:26]),
        .i_entry_ticks (i_s_axis_tdata[41:34]),
        .i_cursor      (i_s_axis_tdata[57:42]),
        .i_priority_req(i_s_axis_tdata[65:58]),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_out_data    (o_m_axis_tdata),
        .o_out_last    (o_m_axis_tlast)
    );

endmodule

`default_nettype wire

// File: bench/square_tone_step_sequencer_core_checker.sv
// ----------------------------------------------------------------------------
// square_tone_step_sequencer_core_checker
// Watches the configuration port and both stream channels, predicts every
// output word of the sequencer and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module square_tone_step_sequencer_core_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire [2:0]   i_cfg_index,
    input  wire [16:0]  i_cfg_data,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    input  wire [71:0]  i_s_tdata,
    input  wire [1:0]   i_s_tuser,
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    input  wire [15:0]  i_m_tdata,
    input  wire         i_m_tlast,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_word_count,
    output int          o_sound_count,
    output int          o_sample_count
);

    typedef struct packed {
        logic               accepted;
        logic signed [13:0] sample;
        logic               playing;
        logic               last;
    } t_word;

    t_word       expected_words[$];
    logic [31:0] steps[stsq_pkg::TABLE_DEPTH];
    logic [10:0] step_count, spt;
    logic [15:0] stop_word, sweep_thr, sweep_base;
    logic [16:0] rate;
    logic        latch_on, muted;
    logic [7:0]  latch_prio;
    logic [15:0] latch_cur, pointer;
    logic [1:0]  mode;
    logic [23:0] phase, phase_inc;
    logic [18:0] tone_left, silence_left;

    function automatic void tune(input logic [15:0] period);
        logic [63:0] sr;
        logic [63:0] inc;
        sr = (rate == 0) ? 64'd1 : 64'(rate);
        muted = period < stsq_pkg::MUTE_LIMIT;
        if (muted) begin
            phase_inc = '0;
            return;
        end
        if (64'd1193182 < 64'd80 * period)
            inc = (64'd80 << stsq_pkg::PHASE_BITS) / sr;
        else if (64'd1193182 > 64'd4200 * period)
            inc = (64'd4200 << stsq_pkg::PHASE_BITS) / sr;
        else
            inc = (64'd1193182 << stsq_pkg::PHASE_BITS) / (64'(period) * sr);
        phase_inc = inc[23:0];
    endfunction

    function automatic bit start_table_step();
        logic [31:0] e;
        int gate, ticks, aud, tone;
        if (pointer >= step_count || pointer >= stsq_pkg::TABLE_DEPTH) return 0;
        e = steps[pointer[9:0]];
        if (e[15:0] == stop_word) return 0;
        gate = e[23:16];
        ticks = (e[31:24] == 0) ? 256 : e[31:24];
        aud = (gate != 0 && gate < ticks) ? gate : ticks;
        tone = aud * spt;
        tone_left = (tone != 0) ? 19'(tone) : 19'd1;
        silence_left = 19'((ticks - aud) * spt);
        tune(e[15:0]);
        return 1;
    endfunction

    function automatic bit start_sweep_step();
        logic [15:0] period;
        period = pointer - sweep_base;
        if ((spt >> 1) == 0) return 0;
        if (period == 0) period = 16'd1;
        tone_left = 19'(spt >> 1);
        silence_left = '0;
        tune(period);
        return 1;
    endfunction

    function automatic t_word play_word(input logic [1:0] op, input logic [71:0] d);
        t_word w;
        bit ok;
        w = '0;
        case (op)
            stsq_pkg::OP_LOAD: steps[d[9:0]] = {d[41:34], d[33:26], d[25:10]};
            stsq_pkg::OP_REQ: begin
                if (!latch_on || (latch_prio - 8'd1) < d[65:58]) begin
                    latch_on = 1;
                    latch_prio = d[65:58];
                    latch_cur = d[57:42];
                    w.accepted = 1;
                end
            end
            stsq_pkg::OP_PUMP: begin
                if (latch_on) begin
                    latch_on = 0;
                    latch_prio = '0;
                    pointer = latch_cur;
                    latch_cur = '0;
                    phase = '0;
                    if (pointer > sweep_thr) begin
                        mode = stsq_pkg::MODE_SWEEP;
                        ok = start_sweep_step();
                    end else begin
                        mode = stsq_pkg::MODE_TABLE;
                        ok = start_table_step();
                    end
                    if (!ok) begin
                        mode = stsq_pkg::MODE_IDLE;
                        tone_left = '0;
                        silence_left = '0;
                    end else begin
                        o_sound_count++;
                    end
                end
            end
            default: begin
                if (mode != stsq_pkg::MODE_IDLE) begin
                    w.playing = 1;
                    o_sample_count++;
                    if (tone_left > 0) begin
                        if (!muted) begin
                            phase = phase + phase_inc;
                            w.sample = phase[23] ? -stsq_pkg::AMP : stsq_pkg::AMP;
                        end
                        tone_left--;
                    end else if (silence_left > 0) begin
                        silence_left--;
                    end
                    if (tone_left == 0 && silence_left == 0) begin
                        if (mode == stsq_pkg::MODE_TABLE) begin
                            pointer = pointer + 16'd1;
                            ok = (pointer != 0) && start_table_step();
                        end else if (pointer < 4 || pointer - 16'd4 <= sweep_thr) begin
                            ok = 0;
                        end else begin
                            pointer = pointer - 16'd4;
                            ok = start_sweep_step();
                        end
                        if (!ok) begin
                            mode = stsq_pkg::MODE_IDLE;
                            tone_left = '0;
                            silence_left = '0;
                            w.last = 1;
                        end
                    end
                end
            end
        endcase
        return w;
    endfunction

    assign o_pending = expected_words.size();

    always @(posedge i_clk) begin
        t_word got, want;
        if (!i_rst_n) begin
            step_count <= 0; stop_word <= 16'hFFFF; spt <= 11'd64;
            rate <= 17'd44100; sweep_thr <= 16'hFFFF; sweep_base <= 0;
            latch_on <= 0; latch_prio <= 0; latch_cur <= 0;
            mode <= stsq_pkg::MODE_IDLE;
            pointer <= 0; phase <= 0; phase_inc <= 0; tone_left <= 0;
            silence_left <= 0; muted <= 0;
            o_fail_count <= 0; o_word_count <= 0;
            o_sound_count <= 0; o_sample_count <= 0;
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    stsq_pkg::CFG_STEP_COUNT:  step_count = i_cfg_data[10:0];
                    stsq_pkg::CFG_STOP_PERIOD: stop_word = i_cfg_data[15:0];
                    stsq_pkg::CFG_SPT:         spt = i_cfg_data[10:0];
                    stsq_pkg::CFG_SAMPLE_RATE: rate = i_cfg_data;
                    stsq_pkg::CFG_SWEEP_THR:   sweep_thr = i_cfg_data[15:0];
                    stsq_pkg::CFG_SWEEP_BASE:  sweep_base = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                expected_words.insert(expected_words.size(),
                                      play_word(i_s_tuser, i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tdata[0], i_m_tdata[14:1], i_m_tdata[15], i_m_tlast};
                o_word_count++;
                if (expected_words.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected output word %h", got);
                end else begin
                    want = expected_words.pop_front();
                    if (got != want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"mismatch: acc %0d/%0d sample %0d/%0d ",
                                      "play %0d/%0d last %0d/%0d"},
                                want.accepted, got.accepted, want.sample, got.sample,
                                want.playing, got.playing, want.last, got.last);
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: bench/square_tone_step_sequencer_core_test.sv
// ----------------------------------------------------------------------------
// square_tone_step_sequencer_core_test
// Loads step tables, drives requests, pumps and sample ticks through several
// configurations with random idling on both streams; the checker compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module square_tone_step_sequencer_core_test;

    logic        clk, rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [16:0] cfg_data;
    logic        s_tvalid, s_tready;
    logic [71:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid, m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;
    int          fail_count, pending, word_count, sound_count, sample_count;
    int          quiet_cycles, loaded_entries;
    bit          calm;

    square_tone_step_sequencer_core uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tlast(m_tlast)
    );

    square_tone_step_sequencer_core_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_s_tuser(s_tuser), .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tlast(m_tlast),
        .o_fail_count(fail_count), .o_pending(pending), .o_word_count(word_count),
        .o_sound_count(sound_count), .o_sample_count(sample_count)
    );

    initial begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Receiver stalls about a third of the time, except in calm stretches.
    always @(posedge clk) begin
        if (!rst_n) m_tready <= 0;
        else m_tready <= calm || ($urandom_range(99) >= 34);
    end

    // No word moving on either stream until quiet_cycles reaches its bound means the block is stuck.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= 4000) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Valid stays high after a word so that the next one can follow at once;
    // drain() drops it.
    task automatic send_word(input logic [1:0] op, input logic [71:0] d);
        while (!calm && $urandom_range(99) < 34) begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= d;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic load_entry(input int idx, input int period, input int gate,
                              input int ticks);
        send_word(stsq_pkg::OP_LOAD, {6'd0, 8'd0, 16'd0, 8'(ticks), 8'(gate),
                  16'(period), 10'(idx)});
    endtask

    task automatic request(input int cur, input int prio);
        send_word(stsq_pkg::OP_REQ, {6'd0, 8'(prio), 16'(cur), 42'd0});
    endtask

    task automatic noise(input logic [1:0] op);
        send_word(op, {6'd0, 66'({$urandom, $urandom, $urandom})});
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int value);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= 17'(value);
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
    endtask

    // Fills the first n entries so that walks never read unwritten entries.
    task automatic fill_table(input int n);
        for (int k = 0; k < n; k++)
            load_entry(k, $urandom_range(3) == 0 ? $urandom_range(40) :
                       $urandom_range(65535), $urandom_range(3) == 0 ? 0 :
                       $urandom_range(255), $urandom_range(4) == 0 ? 0 :
                       $urandom_range(3));
        loaded_entries = n;
    endtask

    task automatic play_sound(input int cur, input int ticks_n);
        request(cur, $urandom_range(255));
        if ($urandom_range(3) == 0) request($urandom_range(65535), $urandom_range(255));
        send_word(stsq_pkg::OP_PUMP, '0);
        for (int k = 0; k < ticks_n; k++) begin
            if ($urandom_range(40) == 0) noise(stsq_pkg::OP_REQ);
            else noise(stsq_pkg::OP_TICK);
        end
    endtask

    initial begin
        int phase_n, cur;
        rst_n = 0; calm = 0; s_tvalid = 0; s_tdata = '0; s_tuser = stsq_pkg::OP_LOAD;
        cfg_we = 0; cfg_index = stsq_pkg::CFG_STEP_COUNT; cfg_data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extreme fields, latch priority rules, stop word, mute, sweep.
        noise(stsq_pkg::OP_TICK);
        send_word(stsq_pkg::OP_PUMP, '0);
        load_entry(0, 16'hFFFF, 0, 0);
        load_entry(1023, 16'h001F, 255, 255);
        load_entry(1, 16'h0020, 1, 2);
        load_entry(2, 16'h0001, 0, 1);
        load_entry(3, 16'hFFFE, 255, 1);
        load_entry(4, 16'hFFFF, 0, 1);
        drain();
        write_reg(stsq_pkg::CFG_STEP_COUNT, 1024);
        write_reg(stsq_pkg::CFG_SPT, 2);
        request(1, 0);
        request(5, 0);
        request(6, 255);
        request(1, 0);
        send_word(stsq_pkg::OP_PUMP, '0);
        repeat (12) noise(stsq_pkg::OP_TICK);
        request(0, 8);
        send_word(stsq_pkg::OP_PUMP, '0);
        noise(stsq_pkg::OP_TICK);
        request(1023, 128);
        send_word(stsq_pkg::OP_PUMP, '0);
        repeat (4) noise(stsq_pkg::OP_TICK);
        drain();
        write_reg(stsq_pkg::CFG_SWEEP_THR, 16'hFFF0);
        write_reg(stsq_pkg::CFG_SWEEP_BASE, 16'hFFF8);
        write_reg(stsq_pkg::CFG_SAMPLE_RATE, 0);
        request(16'hFFFF, 1);
        send_word(stsq_pkg::OP_PUMP, '0);
        repeat (6) noise(stsq_pkg::OP_TICK);
        drain();

        // Random phases, each with its own settings and a fresh table.
        for (phase_n = 0; phase_n < 8; phase_n++) begin
            calm = (phase_n == 3);
            write_reg(stsq_pkg::CFG_STEP_COUNT, (phase_n == 0) ? 0 :
                      (phase_n == 1) ? 1024 : $urandom_range(1, 24));
            write_reg(stsq_pkg::CFG_STOP_PERIOD, (phase_n == 2) ? 0 :
                      $urandom_range(65535));
            write_reg(stsq_pkg::CFG_SPT, (phase_n == 4) ? 1024 : (phase_n % 2) ? 2 :
                      $urandom_range(2, 5));
            write_reg(stsq_pkg::CFG_SAMPLE_RATE, (phase_n == 5) ? 8000 :
                      (phase_n == 6) ? 96000 : $urandom_range(8000, 96000));
            write_reg(stsq_pkg::CFG_SWEEP_THR, (phase_n == 7) ? 0 :
                      $urandom_range(40, 65535));
            write_reg(stsq_pkg::CFG_SWEEP_BASE, (phase_n == 7) ? 65535 :
                      $urandom_range(65535));
            fill_table(phase_n == 1 ? 40 : 24);
            if (phase_n == 1) begin
                drain();
                write_reg(stsq_pkg::CFG_STEP_COUNT, 40);
            end
            if (phase_n == 4) begin
                request(0, 1);
                send_word(stsq_pkg::OP_PUMP, '0);
                repeat (20) noise(stsq_pkg::OP_TICK);
            end else begin
                repeat (6) begin
                    cur = ($urandom_range(3) == 0) ? $urandom_range(65535) :
                          $urandom_range(loaded_entries - 1);
                    play_sound(cur, $urandom_range(5, 26));
                end
            end
            repeat (3) noise(stsq_pkg::OP_LOAD);
            drain();
        end
        // Nothing reads the table after the last phase, so indexes hit by the noise loads stay as they are.
        calm = 0;

        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        $display("checked %0d output words: %0d sounds started, %0d playing samples",
                 word_count, sound_count, sample_count);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
sv/stsq_pkg.sv
sv/stsq_ram.sv
sv/stsq_ctrl.sv
sv/stsq_dp.sv
sv/square_tone_step_sequencer_core.sv
bench/square_tone_step_sequencer_core_checker.sv
bench/square_tone_step_sequencer_core_test.sv
